// ----- rtl/krk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krk_pkg: shared types, constants and saturating helpers
// Q23.40 words with a sticky saturation bit, pipeline latencies, register map.
// ----------------------------------------------------------------------------
package krk_pkg;

    localparam int FRAC_BITS = 40;
    localparam int SPIN_W    = 41;
    localparam int CFG_IDX_W = 8;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SQ = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C  = 8'd3;

    // state lanes
    localparam int IX_U = 0;
    localparam int IX_V = 1;
    localparam int IX_M = 2;
    localparam int IX_W = 3;

    // latencies in cycles
    localparam int MUL_LAT  = 5;
    localparam int DIV_LAT  = 5;
    localparam int DER_LAT  = 3 * MUL_LAT + 2;
    localparam int RK_LAT   = 4 * DER_LAT + 4 * MUL_LAT + 5 + DIV_LAT;
    localparam int STEP_LAT = 2 * RK_LAT;

    typedef logic signed [63:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {63{1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {63{1'b0}}};

    // value plus "something saturated in its cone"
    typedef struct packed {
        logic  sat;
        t_word val;
    } t_fx;

    typedef t_fx   [3:0] t_state;
    typedef t_word [3:0] t_vals;

    typedef struct packed {
        t_word a;
        t_word b3;
        t_word c2;
        t_word s2;
        logic  sat;
    } t_cfg;

    function automatic t_fx fx_add(t_fx x, t_fx y);
        t_fx          r;
        logic [64:0]  s;
        s     = {x.val[63], x.val} + {y.val[63], y.val};
        r.sat = x.sat | y.sat;
        r.val = s[63:0];
        if (s[64] != s[63]) begin
            r.sat = 1'b1;
            r.val = s[64] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

    function automatic t_fx fx_sub(t_fx x, t_fx y);
        t_fx          r;
        logic [64:0]  s;
        s     = {x.val[63], x.val} - {y.val[63], y.val};
        r.sat = x.sat | y.sat;
        r.val = s[63:0];
        if (s[64] != s[63]) begin
            r.sat = 1'b1;
            r.val = s[64] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

    // floor halving
    function automatic t_fx fx_half(t_fx x);
        t_fx r;
        r.sat = x.sat;
        r.val = {x.val[63], x.val[63:1]};
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/krk_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krk_mul: pipelined Q23.40 multiply
// 32-bit partial products, round half up, saturate to 64 bits. MUL_LAT deep.
// ----------------------------------------------------------------------------
module krk_mul (
    input  logic           i_clk,
    input  logic           i_ce,
    input  krk_pkg::t_fx   i_a,
    input  krk_pkg::t_fx   i_b,
    output krk_pkg::t_fx   o_p
);
    import krk_pkg::*;

    localparam logic [64:0] BIAS = 65'(1) << (FRAC_BITS - 1);

    logic [31:0]        a_lo, b_lo;
    logic signed [31:0] a_hi, b_hi;

    logic [63:0]        r_pll;
    logic signed [64:0] r_plh, r_phl;
    logic signed [63:0] r_phh, r_phh2, r_phh3;
    logic signed [65:0] r_mid;
    logic [64:0]        r_lo;
    logic [127:0]       r_q, r_p;
    logic               r_f1, r_f2, r_f3, r_f4;
    t_fx                r_out;
    t_fx                n_out;
    logic               ovf;

    assign a_lo = i_a.val[31:0];
    assign a_hi = i_a.val[63:32];
    assign b_lo = i_b.val[31:0];
    assign b_hi = i_b.val[63:32];

    // all bits above the result must match its sign
    assign ovf = !(&r_p[127:FRAC_BITS+63]) && (|r_p[127:FRAC_BITS+63]);

    always_comb begin
        n_out.sat = r_f4 | ovf;
        n_out.val = r_p[FRAC_BITS+63:FRAC_BITS];
        if (ovf) begin
            n_out.val = r_p[127] ? WORD_MIN : WORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pll  <= a_lo * b_lo;
            r_plh  <= $signed({1'b0, a_lo}) * b_hi;
            r_phl  <= a_hi * $signed({1'b0, b_lo});
            r_phh  <= a_hi * b_hi;
            r_f1   <= i_a.sat | i_b.sat;

            r_mid  <= r_plh + r_phl;
            r_lo   <= {1'b0, r_pll} + BIAS;
            r_phh2 <= r_phh;
            r_f2   <= r_f1;

            r_q    <= {{30{r_mid[65]}}, r_mid, 32'b0} + {63'b0, r_lo};
            r_phh3 <= r_phh2;
            r_f3   <= r_f2;

            r_p    <= r_q + {r_phh3, 64'b0};
            r_f4   <= r_f3;

            r_out  <= n_out;
        end
    end

    assign o_p = r_out;

endmodule
`default_nettype wire

// ----- rtl/krk_div6.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krk_div6: pipelined divide by six
// Round to nearest, ties away from zero, via reciprocal multiply. DIV_LAT deep.
// ----------------------------------------------------------------------------
module krk_div6 (
    input  logic           i_clk,
    input  logic           i_ce,
    input  krk_pkg::t_fx   i_x,
    output krk_pkg::t_fx   o_q
);
    import krk_pkg::*;

    // ceil(2^64 / 3): exact floor(y / 3) for y below 2^63
    localparam logic [31:0] K_LO = 32'h5555_5556;
    localparam logic [31:0] K_HI = 32'h5555_5555;

    logic [63:0] mg;
    logic [62:0] r_y;
    logic [63:0] r_p00, r_p01;
    logic [62:0] r_p10, r_p11, r_p11b;
    logic [65:0] r_t;
    logic [63:0] r_qm;
    logic        r_n1, r_n2, r_n3, r_n4;
    logic        r_f1, r_f2, r_f3, r_f4;
    t_fx         r_out;

    assign mg = i_x.val[63] ? (64'd0 - i_x.val) : i_x.val;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // (|x| + 3) / 6 == ((|x| + 3) >> 1) / 3
            r_y    <= 63'((mg + 64'd3) >> 1);
            r_n1   <= i_x.val[63];
            r_f1   <= i_x.sat;

            r_p00  <= r_y[31:0] * K_LO;
            r_p01  <= r_y[31:0] * K_HI;
            r_p10  <= r_y[62:32] * K_LO;
            r_p11  <= r_y[62:32] * K_HI;
            r_n2   <= r_n1;
            r_f2   <= r_f1;

            r_t    <= {34'b0, r_p00[63:32]} + {2'b0, r_p01} + {3'b0, r_p10};
            r_p11b <= r_p11;
            r_n3   <= r_n2;
            r_f3   <= r_f2;

            r_qm   <= {1'b0, r_p11b} + {30'b0, r_t[65:32]};
            r_n4   <= r_n3;
            r_f4   <= r_f3;

            r_out.sat <= r_f4;
            r_out.val <= r_n4 ? (64'd0 - r_qm) : r_qm;
        end
    end

    assign o_q = r_out;

endmodule
`default_nettype wire

// ----- rtl/krk_deriv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krk_deriv: derivative pipeline
// (u, v, m, w) -> (v, u(A + u(3B - 2Cu)), w, m(A - 2S m m)), DER_LAT deep.
// ----------------------------------------------------------------------------
module krk_deriv (
    input  logic              i_clk,
    input  logic              i_ce,
    input  krk_pkg::t_cfg     i_cfg,
    input  krk_pkg::t_state   i_y,
    output krk_pkg::t_state   o_k
);
    import krk_pkg::*;

    t_state r_yd [DER_LAT];

    t_fx a_fx, b3_fx, c2_fx, s2_fx;
    t_fx p_cu, p_sm, p_smm, p_ui, p_uai, p_md;
    t_fx r_inner, r_ai, r_am, r_d3;

    assign a_fx  = {1'b0, i_cfg.a};
    assign b3_fx = {i_cfg.sat, i_cfg.b3};
    assign c2_fx = {1'b0, i_cfg.c2};
    assign s2_fx = {1'b0, i_cfg.s2};

    // u branch
    krk_mul u_cu  (.i_clk, .i_ce, .i_a(c2_fx), .i_b(i_y[IX_U]), .o_p(p_cu));
    krk_mul u_ui  (.i_clk, .i_ce, .i_a(r_yd[MUL_LAT][IX_U]), .i_b(r_inner), .o_p(p_ui));
    krk_mul u_uai (.i_clk, .i_ce, .i_a(r_yd[2*MUL_LAT+1][IX_U]), .i_b(r_ai),
                   .o_p(p_uai));

    // m branch
    krk_mul u_sm  (.i_clk, .i_ce, .i_a(s2_fx), .i_b(i_y[IX_M]), .o_p(p_sm));
    krk_mul u_smm (.i_clk, .i_ce, .i_a(p_sm), .i_b(r_yd[MUL_LAT-1][IX_M]), .o_p(p_smm));
    krk_mul u_md  (.i_clk, .i_ce, .i_a(r_yd[2*MUL_LAT][IX_M]), .i_b(r_am), .o_p(p_md));

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_yd[0] <= i_y;
            for (int i = 1; i < DER_LAT; i++) begin
                r_yd[i] <= r_yd[i-1];
            end
            r_inner <= fx_sub(b3_fx, p_cu);
            r_ai    <= fx_add(a_fx, p_ui);
            r_am    <= fx_sub(a_fx, p_smm);
            r_d3    <= p_md;
        end
    end

    assign o_k[IX_U] = r_yd[DER_LAT-1][IX_V];
    assign o_k[IX_V] = p_uai;
    assign o_k[IX_M] = r_yd[DER_LAT-1][IX_W];
    assign o_k[IX_W] = r_d3;

endmodule
`default_nettype wire

// ----- rtl/krk_rk4.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krk_rk4: one classical RK4 step
// Four derivative passes, stage states, weighted sum, h*sum/6 update. RK_LAT deep.
// ----------------------------------------------------------------------------
module krk_rk4 (
    input  logic              i_clk,
    input  logic              i_ce,
    input  krk_pkg::t_cfg     i_cfg,
    input  krk_pkg::t_state   i_y,
    input  krk_pkg::t_word    i_h,
    output krk_pkg::t_state   o_y,
    output krk_pkg::t_word    o_h
);
    import krk_pkg::*;

    // arrival times relative to i_y
    localparam int T_T2   = DER_LAT + MUL_LAT + 1;
    localparam int T_K2   = T_T2 + DER_LAT;
    localparam int T_T3   = T_K2 + MUL_LAT + 1;
    localparam int T_K3   = T_T3 + DER_LAT;
    localparam int T_T4   = T_K3 + MUL_LAT + 1;
    localparam int T_K4   = T_T4 + DER_LAT;
    localparam int T_Q    = T_K4 + 1 + MUL_LAT + DIV_LAT;
    localparam int K1_DLY = T_K2 + 1 - DER_LAT;
    localparam int S1_DLY = DER_LAT + MUL_LAT;
    localparam int S2_DLY = DER_LAT + MUL_LAT - 1;

    t_state r_yl  [T_Q];
    t_word  r_hl  [RK_LAT];
    t_state r_k1l [K1_DLY];
    t_state r_s1l [S1_DLY];
    t_state r_s2l [S2_DLY];

    t_state k1, k2, k3, k4;
    t_state hk1, hk2, hk3, hs, q6;
    t_state r_t2, r_t3, r_t4, r_d2, r_s1, r_d3, r_s2, r_s3, r_out;
    t_fx    h_k1, h_k2, h_k3, h_s;

    assign h_k1 = {1'b0, r_hl[DER_LAT-1]};
    assign h_k2 = {1'b0, r_hl[T_K2-1]};
    assign h_k3 = {1'b0, r_hl[T_K3-1]};
    assign h_s  = {1'b0, r_hl[T_K4]};

    krk_deriv u_der1 (.i_clk, .i_ce, .i_cfg, .i_y(i_y),  .o_k(k1));
    krk_deriv u_der2 (.i_clk, .i_ce, .i_cfg, .i_y(r_t2), .o_k(k2));
    krk_deriv u_der3 (.i_clk, .i_ce, .i_cfg, .i_y(r_t3), .o_k(k3));
    krk_deriv u_der4 (.i_clk, .i_ce, .i_cfg, .i_y(r_t4), .o_k(k4));

    for (genvar j = 0; j < 4; j++) begin : g_lane
        krk_mul  u_hk1 (.i_clk, .i_ce, .i_a(h_k1), .i_b(k1[j]),   .o_p(hk1[j]));
        krk_mul  u_hk2 (.i_clk, .i_ce, .i_a(h_k2), .i_b(k2[j]),   .o_p(hk2[j]));
        krk_mul  u_hk3 (.i_clk, .i_ce, .i_a(h_k3), .i_b(k3[j]),   .o_p(hk3[j]));
        krk_mul  u_hs  (.i_clk, .i_ce, .i_a(h_s),  .i_b(r_s3[j]), .o_p(hs[j]));
        krk_div6 u_div (.i_clk, .i_ce, .i_x(hs[j]), .o_q(q6[j]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_yl[0]  <= i_y;
            for (int i = 1; i < T_Q; i++) begin
                r_yl[i] <= r_yl[i-1];
            end
            r_hl[0]  <= i_h;
            for (int i = 1; i < RK_LAT; i++) begin
                r_hl[i] <= r_hl[i-1];
            end
            r_k1l[0] <= k1;
            for (int i = 1; i < K1_DLY; i++) begin
                r_k1l[i] <= r_k1l[i-1];
            end
            r_s1l[0] <= r_s1;
            for (int i = 1; i < S1_DLY; i++) begin
                r_s1l[i] <= r_s1l[i-1];
            end
            r_s2l[0] <= r_s2;
            for (int i = 1; i < S2_DLY; i++) begin
                r_s2l[i] <= r_s2l[i-1];
            end

            for (int j = 0; j < 4; j++) begin
                r_t2[j]  <= fx_add(r_yl[DER_LAT+MUL_LAT-1][j], fx_half(hk1[j]));
                r_t3[j]  <= fx_add(r_yl[T_K2+MUL_LAT-1][j], fx_half(hk2[j]));
                r_t4[j]  <= fx_add(r_yl[T_K3+MUL_LAT-1][j], hk3[j]);
                // weighted sum k1 + 2k2 + 2k3 + k4, built as the k's arrive
                r_d2[j]  <= fx_add(k2[j], k2[j]);
                r_s1[j]  <= fx_add(r_k1l[K1_DLY-1][j], r_d2[j]);
                r_d3[j]  <= fx_add(k3[j], k3[j]);
                r_s2[j]  <= fx_add(r_s1l[S1_DLY-1][j], r_d3[j]);
                r_s3[j]  <= fx_add(r_s2l[S2_DLY-1][j], k4[j]);
                r_out[j] <= fx_add(r_yl[T_Q-1][j], q6[j]);
            end
        end
    end

    assign o_y = r_out;
    assign o_h = r_hl[RK_LAT-1];

endmodule
`default_nettype wire

// ----- rtl/kerr_geodesic_rk4_step_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kerr_geodesic_rk4_step_unit: streaming RK4 step for separated Kerr geodesics
// Advances (u, v, m, w) by one step of h, or two steps of h/2, in Q23.40.
// ----------------------------------------------------------------------------
// Fully pipelined: while nothing stalls, one word is accepted per cycle and one
// result word leaves per cycle. Two RK4 step pipelines sit in series between
// the input register and the output register; each
// holds four derivative passes of three chained pipelined 64x64 multipliers
// plus the h*k updates and a reciprocal divide by six, which sets RK_LAT.
// A full step (op = 0) runs through the first RK4 pipeline and a matching
// delay line; two half steps (op = 1) use both. The whole pipeline advances on
// one enable, held only while the two-entry output buffer is full, so a stalled
// consumer loses or repeats nothing. The overflow flag (tuser) is set when any
// saturating operation of the word's step clipped, including 3B or 2C.
// Configuration writes are always ready; write only while the block is idle.
// ----------------------------------------------------------------------------
module kerr_geodesic_rk4_step_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [krk_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                       i_cfg_data,

    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: step_size, inv_radius, inv_radius_rate, polar_cos, polar_cos_rate
    input  logic [319:0]                      s_axis_tdata,
    // tuser: op
    input  logic [0:0]                        s_axis_tuser,

    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: new_inv_radius, new_inv_radius_rate, new_polar_cos, new_polar_cos_rate
    output logic [255:0]                      m_axis_tdata,
    // tuser: overflow
    output logic [0:0]                        m_axis_tuser
);
    import krk_pkg::*;

    // ---------------- configuration ----------------
    logic [SPIN_W-1:0] r_spin;
    t_word             r_coef_a, r_coef_b, r_coef_c;
    t_cfg              r_cfg, n_cfg;
    t_fx               b_fx, c_fx, b2_fx, b3_fx, c2_fx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin   <= '0;
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPIN_SQ: r_spin   <= i_cfg_data[SPIN_W-1:0];
                CFG_COEF_A:  r_coef_a <= i_cfg_data;
                CFG_COEF_B:  r_coef_b <= i_cfg_data;
                CFG_COEF_C:  r_coef_c <= i_cfg_data;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // 3B, 2C and 2S are item independent: compute once, keep the clip flag of 3B and 2C
    assign b_fx  = {1'b0, r_coef_b};
    assign c_fx  = {1'b0, r_coef_c};
    assign b2_fx = fx_add(b_fx, b_fx);
    assign b3_fx = fx_add(b2_fx, b_fx);
    assign c2_fx = fx_add(c_fx, c_fx);

    always_comb begin
        n_cfg.a   = r_coef_a;
        n_cfg.b3  = b3_fx.val;
        n_cfg.c2  = c2_fx.val;
        n_cfg.s2  = {{(63 - SPIN_W){1'b0}}, r_spin, 1'b0};
        n_cfg.sat = b3_fx.sat | c2_fx.sat;
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // ---------------- pipeline enable ----------------
    logic r_sk_v;
    logic ce;

    assign ce            = ~r_sk_v;
    assign s_axis_tready = ce;

    // ---------------- input stage ----------------
    logic   r_in_v, r_in_op;
    t_word  r_in_h;
    t_state r_in_y;
    t_word  h_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (ce) begin
            r_in_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_in_op <= s_axis_tuser[0];
            r_in_h  <= s_axis_tdata[63:0];
            for (int j = 0; j < 4; j++) begin
                r_in_y[j] <= {1'b0, s_axis_tdata[64*j+64 +: 64]};
            end
        end
    end

    // two half steps: h/2 by floor halving
    assign h_run = r_in_op ? {r_in_h[63], r_in_h[63:1]} : r_in_h;

    // ---------------- RK4 pipelines ----------------
    t_state mid_y, fin_y;
    t_word  mid_h;

    krk_rk4 u_rk_a (
        .i_clk, .i_ce(ce), .i_cfg(r_cfg),
        .i_y(r_in_y), .i_h(h_run), .o_y(mid_y), .o_h(mid_h)
    );

    krk_rk4 u_rk_b (
        .i_clk, .i_ce(ce), .i_cfg(r_cfg),
        .i_y(mid_y), .i_h(mid_h), .o_y(fin_y), .o_h()
    );

    // valid and op travel with the word; full-step results wait in a bypass line
    logic   r_vl  [STEP_LAT];
    logic   r_opl [STEP_LAT];
    t_state r_bpl [RK_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STEP_LAT; i++) begin
                r_vl[i] <= 1'b0;
            end
        end else if (ce) begin
            r_vl[0] <= r_in_v;
            for (int i = 1; i < STEP_LAT; i++) begin
                r_vl[i] <= r_vl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_opl[0] <= r_in_op;
            for (int i = 1; i < STEP_LAT; i++) begin
                r_opl[i] <= r_opl[i-1];
            end
            r_bpl[0] <= mid_y;
            for (int i = 1; i < RK_LAT; i++) begin
                r_bpl[i] <= r_bpl[i-1];
            end
        end
    end

    // ---------------- result select ----------------
    t_state res_y;
    t_vals  res_vals;
    logic   res_ovf;
    logic   last_v;

    assign last_v = r_vl[STEP_LAT-1];
    assign res_y  = r_opl[STEP_LAT-1] ? fin_y : r_bpl[RK_LAT-1];

    always_comb begin
        res_ovf = 1'b0;
        for (int j = 0; j < 4; j++) begin
            res_vals[j] = res_y[j].val;
            res_ovf     = res_ovf | res_y[j].sat;
        end
    end

    // ---------------- output register + skid ----------------
    logic  r_out_v, r_out_ovf, r_sk_ovf;
    t_vals r_out_vals, r_sk_vals;
    logic  take;

    assign take = r_out_v & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            // pipeline frozen; drain skid into output slot
            if (take) begin
                r_out_vals <= r_sk_vals;
                r_out_ovf  <= r_sk_ovf;
                r_sk_v     <= 1'b0;
            end
        end else if (!r_out_v || take) begin
            r_out_v    <= last_v;
            r_out_vals <= res_vals;
            r_out_ovf  <= res_ovf;
        end else if (last_v) begin
            r_sk_v    <= 1'b1;
            r_sk_vals <= res_vals;
            r_sk_ovf  <= res_ovf;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_vals;
    assign m_axis_tuser  = r_out_ovf;

endmodule
`default_nettype wire

// ----- tb/sv/kerr_geodesic_rk4_step_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kerr_geodesic_rk4_step_unit_tb: self-checking bench for the RK4 step unit
// Drives state words through the input stream, predicts each step in Q23.40
// with saturation tracking, and compares every output word field by field.
// ----------------------------------------------------------------------------
module kerr_geodesic_rk4_step_unit_tb;
    import krk_pkg::*;

    localparam int    LAT_CYCLES = 2 * RK_LAT + 1;
    localparam t_word ONE        = 64'sh0000_0100_0000_0000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    kerr_geodesic_rk4_step_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: shadow registers and saturating Q23.40 arithmetic
    // ------------------------------------------------------------------------
    logic [40:0] sh_spin;
    t_word       sh_a, sh_b, sh_c;
    bit          clipped;   // sticky per step

    typedef struct {
        t_word vals[4];
        bit    ovf;
        bit    chk;        // expect exp_vals flag
        t_word exp_vals[4];
    } t_step_word;

    t_step_word pending_steps[$];
    int         n_err = 0;
    int         send_idle_pct, recv_idle_pct;

    function automatic t_word sat_add(t_word x, t_word y);
        logic signed [64:0] s;
        s = x + y;
        if (s > 65'sd9223372036854775807) begin clipped = 1; return WORD_MAX; end
        if (s < -65'sd9223372036854775808) begin clipped = 1; return WORD_MIN; end
        return s[63:0];
    endfunction

    function automatic t_word sat_sub(t_word x, t_word y);
        logic signed [64:0] s;
        s = x - y;
        if (s > 65'sd9223372036854775807) begin clipped = 1; return WORD_MAX; end
        if (s < -65'sd9223372036854775808) begin clipped = 1; return WORD_MIN; end
        return s[63:0];
    endfunction

    // round to nearest, ties up, via floor of (p + half)
    function automatic t_word sat_mul(t_word x, t_word y);
        logic signed [129:0] p;
        p = x * y;
        p = p + (130'sd1 <<< (FRAC_BITS - 1));
        p = p >>> FRAC_BITS;
        if (p > 130'sd9223372036854775807) begin clipped = 1; return WORD_MAX; end
        if (p < -130'sd9223372036854775808) begin clipped = 1; return WORD_MIN; end
        return p[63:0];
    endfunction

    function automatic t_word halve(t_word x);
        return x >>> 1;
    endfunction

    // nearest, ties away from zero
    function automatic t_word div_six(t_word x);
        logic [64:0] mg, q;
        mg = x[63] ? -{1'b1, x} : {1'b0, x};
        q  = mg / 6;
        if (mg % 6 >= 3) q = q + 1;
        return x[63] ? t_word'(-q) : t_word'(q);
    endfunction

    function automatic void geodesic_rates(input t_word y[4], output t_word d[4]);
        t_word b3, c2, inner, s2m2;
        b3    = sat_add(sat_add(sh_b, sh_b), sh_b);
        c2    = sat_add(sh_c, sh_c);
        inner = sat_sub(b3, sat_mul(c2, y[0]));
        s2m2  = sat_mul(sat_mul(sat_add({23'd0, sh_spin}, {23'd0, sh_spin}), y[2]), y[2]);
        d[0]  = y[1];
        d[1]  = sat_mul(y[0], sat_add(sh_a, sat_mul(y[0], inner)));
        d[2]  = y[3];
        d[3]  = sat_mul(y[2], sat_sub(sh_a, s2m2));
    endfunction

    function automatic void rk4_advance(input t_word y[4], input t_word h,
                                        output t_word r[4]);
        t_word k1[4], k2[4], k3[4], k4[4], t[4], s;
        geodesic_rates(y, k1);
        for (int j = 0; j < 4; j++) t[j] = sat_add(y[j], halve(sat_mul(h, k1[j])));
        geodesic_rates(t, k2);
        for (int j = 0; j < 4; j++) t[j] = sat_add(y[j], halve(sat_mul(h, k2[j])));
        geodesic_rates(t, k3);
        for (int j = 0; j < 4; j++) t[j] = sat_add(y[j], sat_mul(h, k3[j]));
        geodesic_rates(t, k4);
        for (int j = 0; j < 4; j++) begin
            s    = sat_add(k1[j], sat_add(k2[j], k2[j]));
            s    = sat_add(s, sat_add(k3[j], k3[j]));
            s    = sat_add(s, k4[j]);
            r[j] = sat_add(y[j], div_six(sat_mul(h, s)));
        end
    endfunction

    function automatic void predict_step(input bit op, input t_word h, input t_word y[4],
                                         output t_word r[4], output bit ovf);
        t_word mid[4];
        clipped = 0;
        if (!op) rk4_advance(y, h, r);
        else begin
            rk4_advance(y, halve(h), mid);
            rk4_advance(mid, halve(h), r);
        end
        ovf = clipped;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_err++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_word rand_word();
        t_word w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return w;                                   // full range
            1:       return $urandom_range(0, 3) == 0 ? WORD_MIN :
                           ($urandom_range(0, 1) ? WORD_MAX : 64'sd0);
            default: return w >>> (24 + $urandom_range(0, 20));  // magnitude below one half
        endcase
    endfunction

    // valid stays high after the write; the caller drops it after its last write
    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SPIN_SQ: sh_spin = val[40:0];
            CFG_COEF_A:  sh_a = val;
            CFG_COEF_B:  sh_b = val;
            CFG_COEF_C:  sh_c = val;
            default: ;
        endcase
    endtask

    // queue-then-drive; when chk is set, exp_vals and want_ovf override the predictor
    task automatic send_step(input bit op, input t_word h, input t_word y[4],
                             input bit chk, input t_word want[4], input bit want_ovf);
        t_step_word e;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        predict_step(op, h, y, e.vals, e.ovf);
        e.chk = chk;
        e.exp_vals = want;
        if (chk) e.ovf = want_ovf;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {y[3], y[2], y[1], y[0], h};
        pending_steps.push_back(e);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES + 10) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output checker and receiver stall
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_step_word e;
        t_word      got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_steps.size() == 0) begin
                report_mismatch("unexpected word", t_word'(m_axis_tdata[63:0]), '0);
            end else begin
                e = pending_steps.pop_front();
                for (int j = 0; j < 4; j++) begin
                    got = m_axis_tdata[64*j +: 64];
                    if (got !== (e.chk ? e.exp_vals[j] : e.vals[j]))
                        report_mismatch($sformatf("lane %0d", j), got,
                                        e.chk ? e.exp_vals[j] : e.vals[j]);
                end
                if (m_axis_tuser[0] !== e.ovf)
                    report_mismatch("overflow", t_word'(m_axis_tuser),
                                    t_word'(e.ovf));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Directed table then random phases
    // ------------------------------------------------------------------------
    typedef struct {
        bit    op;
        t_word h;
        t_word y[4];
        bit    chk;
        t_word want[4];
        bit    ovf;
    } t_dir_row;

    initial begin
        t_dir_row dir_rows[$];
        t_word    y[4], none[4];
        none = '{0, 0, 0, 0};
        send_idle_pct = 7;
        recv_idle_pct = 64;
        sh_spin = '0; sh_a = 0; sh_b = 0; sh_c = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero coefficients after reset: u, m stepped by h*v and h*w only
        dir_rows.push_back('{0, 0, '{0, 0, 0, 0}, 1, '{0, 0, 0, 0}, 0});
        dir_rows.push_back('{1, ONE, '{ONE, 0, ONE, 0}, 1, '{ONE, 0, ONE, 0}, 0});
        dir_rows.push_back('{0, ONE, '{0, ONE, 0, ONE}, 1, '{ONE, ONE, ONE, ONE}, 0});
        // extreme values saturate the state update
        dir_rows.push_back('{0, ONE, '{WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN}, 1,
                             '{WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN}, 1});
        dir_rows.push_back('{1, WORD_MAX, '{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN},
                             0, none, 0});
        dir_rows.push_back('{0, WORD_MIN, '{WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX},
                             0, none, 0});
        dir_rows.push_back('{1, -ONE, '{ONE, -ONE, ONE >>> 1, -ONE}, 0, none, 0});
        foreach (dir_rows[i])
            send_step(dir_rows[i].op, dir_rows[i].h, dir_rows[i].y,
                      dir_rows[i].chk, dir_rows[i].want, dir_rows[i].ovf);
        drain_all();

        // physical settings, spin above one, extremes, ignored index
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SPIN_SQ, ONE >>> 1);  write_reg(CFG_COEF_A, -(ONE * 12));
                    write_reg(CFG_COEF_B, ONE * 14);    write_reg(CFG_COEF_C, ONE >>> 2);
                end
                1: begin
                    write_reg(CFG_SPIN_SQ, ONE);        write_reg(CFG_COEF_A, ONE);
                    write_reg(CFG_COEF_B, ONE * 3);     write_reg(CFG_COEF_C, ONE);
                end
                2: begin
                    write_reg(CFG_SPIN_SQ, {41{1'b1}}); write_reg(CFG_COEF_A, WORD_MAX);
                    write_reg(CFG_COEF_B, WORD_MAX);    write_reg(CFG_COEF_C, WORD_MIN);
                end
                3: begin
                    write_reg(CFG_SPIN_SQ, 0);          write_reg(CFG_COEF_A, WORD_MIN);
                    write_reg(CFG_COEF_B, WORD_MIN);    write_reg(CFG_COEF_C, WORD_MAX);
                end
                4: begin
                    write_reg(8'd200, {$urandom, $urandom});
                    write_reg(CFG_SPIN_SQ, {$urandom, $urandom});
                    write_reg(CFG_COEF_A, rand_word()); write_reg(CFG_COEF_B, rand_word());
                    write_reg(CFG_COEF_C, rand_word());
                end
                default: begin
                    write_reg(CFG_SPIN_SQ, $urandom_range(0, 1 << 30) << 10);
                    write_reg(CFG_COEF_A, -(ONE * 5));  write_reg(CFG_COEF_B, ONE * 6);
                    write_reg(CFG_COEF_C, ONE >>> 3);
                end
            endcase
            i_cfg_valid <= 1'b0;
            if (phase == 2) begin send_idle_pct = 64; recv_idle_pct = 7; end
            if (phase == 4) begin send_idle_pct = 0;  recv_idle_pct = 0; end
            for (int n = 0; n < 215; n++) begin
                for (int j = 0; j < 4; j++) y[j] = rand_word();
                send_step($urandom_range(0, 1), rand_word(), y, 0, none, 0);
            end
            drain_all();
        end

        if (n_err == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
